// ----- hw/rtl/dvru_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the distance vector route update block.
// No dependencies; imported by dvru_table and distance_vector_route_update.
package dvru_pkg;

  localparam int NODES  = 8;
  localparam int NODE_W = $clog2(NODES);
  localparam int COST_W = 14;
  localparam int HOP_W  = 4;
  localparam int OP_W   = 2;

  localparam logic [COST_W-1:0] INF_COST = COST_W'(10000);
  localparam logic [HOP_W-1:0]  NO_LINK  = HOP_W'(15);

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_VECTOR = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef logic [NODE_W-1:0] node_idx_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [2:0]        neighbor;
    logic [HOP_W-1:0]  link;
    logic [COST_W-1:0] link_cost;
    logic [2:0]        dest_index;
    logic [COST_W-1:0] advertised_cost;
    logic              first_element;
    logic              last_element;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [COST_W-1:0] route_cost;
    logic [HOP_W-1:0]  next_link;
    logic              updated;
  } rsp_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [HOP_W-1:0]  hop;
  } entry_t;

  // Port A carries the direct-link overwrite, port B the relaxation.
  typedef struct packed {
    logic      clear;
    node_idx_t clr_own;
    logic      a_en;
    node_idx_t a_addr;
    entry_t    a_data;
    logic      b_en;
    node_idx_t b_addr;
    entry_t    b_data;
  } tbl_wr_t;

endpackage

// ----- hw/rtl/dvru_table.sv -----
`timescale 1ns / 1ps
// Route table: two banks with one write port each, a per-entry bank select,
// valid bits that clear the whole table at once, and bypass of the last cycle's writes. Uses dvru_pkg.
module dvru_table import dvru_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      rd_en,
  input  node_idx_t rd_addr_n,
  input  node_idx_t rd_addr_d,
  input  tbl_wr_t   wr,
  output entry_t    ent_n,
  output entry_t    ent_d
);

  entry_t bank_a [NODES];
  entry_t bank_b [NODES];

  entry_t    rda_n, rda_d, rdb_n, rdb_d;
  node_idx_t addr_n, addr_d;

  logic [NODES-1:0] valid;
  logic [NODES-1:0] newer;
  node_idx_t        clr_own;
  tbl_wr_t          fwd;

  function automatic entry_t pick(node_idx_t x, entry_t ra, entry_t rb,
                                  logic [NODES-1:0] vld, logic [NODES-1:0] nw,
                                  tbl_wr_t f, node_idx_t own);
    entry_t fa;
    entry_t fb;
    entry_t res;
    fa = (f.a_en && f.a_addr == x) ? f.a_data : ra;
    fb = (f.b_en && f.b_addr == x) ? f.b_data : rb;
    if (!vld[x]) begin
      if (x == own) begin
        res.cost = '0;
        res.hop  = HOP_W'(own);
      end else begin
        res.cost = INF_COST;
        res.hop  = NO_LINK;
      end
    end else begin
      res = nw[x] ? fb : fa;
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (wr.a_en) begin
      bank_a[wr.a_addr] <= wr.a_data;
    end
    if (rd_en) begin
      rda_n <= bank_a[rd_addr_n];
      rda_d <= bank_a[rd_addr_d];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.b_en) begin
      bank_b[wr.b_addr] <= wr.b_data;
    end
    if (rd_en) begin
      rdb_n <= bank_b[rd_addr_n];
      rdb_d <= bank_b[rd_addr_d];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_n <= rd_addr_n;
      addr_d <= rd_addr_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      newer   <= '0;
      clr_own <= '0;
      fwd     <= '0;
    end else begin
      fwd <= wr;
      if (wr.clear) begin
        valid   <= '0;
        clr_own <= wr.clr_own;
      end else begin
        if (wr.a_en) begin
          valid[wr.a_addr] <= 1'b1;
          newer[wr.a_addr] <= 1'b0;
        end
        if (wr.b_en) begin
          valid[wr.b_addr] <= 1'b1;
          newer[wr.b_addr] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    ent_n = pick(addr_n, rda_n, rdb_n, valid, newer, fwd, clr_own);
    ent_d = pick(addr_d, rda_d, rdb_d, valid, newer, fwd, clr_own);
  end

endmodule

// ----- hw/rtl/distance_vector_route_update.sv -----
`timescale 1ns / 1ps
// Distance vector route update, top level. Uses dvru_pkg and dvru_table.
// A taken request is registered in r together with the table read, then relaxed
// and written back; its result strobe (done) is registered alongside that write.
// Throughput: one request per cycle, set by the registered table read plus
// one compare-and-write stage. The receiver cannot stall; busy is high only in reset.
// Reset: own_node is 0, the table returns to its clear state, the change flag drops.
module distance_vector_route_update import dvru_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  output logic       done,
  output rsp_t       rsp
);

  logic [2:0] own_reg;
  logic       accept;
  logic       s1_vld;
  req_t       r;
  logic       changed;
  logic       changed_next;
  entry_t     ent_n, ent_d;
  tbl_wr_t    wr;
  logic       done_next;
  rsp_t       rsp_next;

  logic              direct;
  logic              relax;
  logic              chg0;
  logic              chg1;
  logic [COST_W-1:0] ncost;
  logic [COST_W-1:0] dcost;
  logic [COST_W:0]   sum;

  assign busy     = rst;
  assign accept   = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_reg <= '0;
    end else if (cfg_we) begin
      own_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r <= req;
    end
  end

  dvru_table u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_n (node_idx_t'(req.neighbor)),
    .rd_addr_d (node_idx_t'(req.dest_index)),
    .wr        (wr),
    .ent_n     (ent_n),
    .ent_d     (ent_d)
  );

  always_comb begin
    direct = r.first_element && (ent_n.cost != r.link_cost);
    ncost  = direct ? r.link_cost : ent_n.cost;
    dcost  = (direct && r.dest_index == r.neighbor) ? r.link_cost : ent_d.cost;
    sum    = {1'b0, r.advertised_cost} + {1'b0, ncost};
    relax  = {1'b0, dcost} > sum;
    chg0   = r.first_element ? 1'b0 : changed;
    chg1   = chg0 || direct || relax;
  end

  always_comb begin
    wr           = '0;
    wr.clr_own   = node_idx_t'(own_reg);
    wr.a_addr    = node_idx_t'(r.neighbor);
    wr.a_data    = '{cost: r.link_cost, hop: r.link};
    wr.b_addr    = node_idx_t'(r.dest_index);
    wr.b_data    = '{cost: sum[COST_W-1:0], hop: r.link};
    changed_next = changed;
    done_next    = 1'b0;
    rsp_next     = '0;
    if (s1_vld) begin
      case (r.operation)
        OP_CLEAR: begin
          wr.clear     = 1'b1;
          changed_next = 1'b0;
        end
        OP_VECTOR: begin
          wr.a_en = direct;
          wr.b_en = relax;
          if (r.last_element) begin
            done_next        = 1'b1;
            rsp_next.kind    = KIND_UPDATE;
            rsp_next.updated = chg1;
            changed_next     = 1'b0;
          end else begin
            changed_next = chg1;
          end
        end
        OP_LOOKUP: begin
          done_next           = 1'b1;
          rsp_next.kind       = KIND_LOOKUP;
          rsp_next.route_cost = ent_d.cost;
          rsp_next.next_link  = ent_d.hop;
        end
        default: begin
          done_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      changed <= 1'b0;
      done    <= 1'b0;
    end else begin
      changed <= changed_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

`ifndef SYNTHESIS
  a_write_ports_apart: assert property (@(posedge clk) disable iff (rst)
    (wr.a_en && wr.b_en) |-> (wr.a_addr != wr.b_addr))
    else $error("both table ports write one entry");

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a request");

  a_update_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.kind == KIND_UPDATE) |-> (rsp.route_cost == '0 && rsp.next_link == '0))
    else $error("update result carries lookup fields");

  a_flag_drops_at_end: assert property (@(posedge clk) disable iff (rst)
    (s1_vld && r.operation == OP_VECTOR && r.last_element) |=> !changed)
    else $error("change flag held past end of vector");

  a_clear_writes_nothing: assert property (@(posedge clk) disable iff (rst)
    wr.clear |-> (!wr.a_en && !wr.b_en && !done_next))
    else $error("clear request wrote the table or produced a result");
`endif

endmodule

// ----- tb/sv/tb_distance_vector_route_update.sv -----
`timescale 1ns / 1ps
// Self-checking bench for distance_vector_route_update: route table model, request driver, result check.
// Depends on dvru_pkg (types, constants) and the distance_vector_route_update RTL.
module tb_distance_vector_route_update import dvru_pkg::*; ();

  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class route_table_model;
    logic [COST_W-1:0] cost_tbl [NODES];
    logic [HOP_W-1:0]  hop_tbl [NODES];
    bit                changed;
    logic [2:0]        own_node;
    rsp_t              expected_rsp [$];
    int                mismatches;

    function new();
      own_node = 3'd0;
      mismatches = 0;
      clear_table();
    endfunction

    function void clear_table();
      for (int i = 0; i < NODES; i++) begin
        cost_tbl[i] = INF_COST;
        hop_tbl[i] = NO_LINK;
      end
      if (own_node < NODES) begin
        cost_tbl[own_node] = '0;
        hop_tbl[own_node] = HOP_W'(own_node);
      end
      changed = 1'b0;
    endfunction

    function void set_own(logic [2:0] v);
      own_node = v;
    endfunction

    function void note_request(req_t r);
      rsp_t              e;
      logic [COST_W:0]   sum;
      e = '0;
      case (r.operation)
        OP_CLEAR: begin
          clear_table();
        end
        OP_LOOKUP: begin
          e.kind = KIND_LOOKUP;
          e.route_cost = (r.dest_index < NODES) ? cost_tbl[r.dest_index] : INF_COST;
          e.next_link = (r.dest_index < NODES) ? hop_tbl[r.dest_index] : NO_LINK;
          e.updated = 1'b0;
          expected_rsp.push_back(e);
        end
        OP_VECTOR: begin
          if (r.first_element) changed = 1'b0;
          if (r.neighbor < NODES) begin
            if (r.first_element && cost_tbl[r.neighbor] != r.link_cost) begin
              cost_tbl[r.neighbor] = r.link_cost;
              hop_tbl[r.neighbor] = r.link;
              changed = 1'b1;
            end
            sum = {1'b0, r.advertised_cost} + {1'b0, cost_tbl[r.neighbor]};
            if (r.dest_index < NODES && {1'b0, cost_tbl[r.dest_index]} > sum) begin
              cost_tbl[r.dest_index] = sum[COST_W-1:0];
              hop_tbl[r.dest_index] = r.link;
              changed = 1'b1;
            end
          end
          if (r.last_element) begin
            e.kind = KIND_UPDATE;
            e.updated = changed;
            expected_rsp.push_back(e);
            changed = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_rsp.size() == 0) begin
        $error("unexpected result: kind %0d cost %0d link %0d updated %0d",
               got.kind, got.route_cost, got.next_link, got.updated);
        mismatches++;
        return;
      end
      e = expected_rsp.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, got.kind);
        mismatches++;
      end
      if (got.route_cost !== e.route_cost) begin
        $error("route_cost: expected %0d, actual %0d", e.route_cost, got.route_cost);
        mismatches++;
      end
      if (got.next_link !== e.next_link) begin
        $error("next_link: expected %0d, actual %0d", e.next_link, got.next_link);
        mismatches++;
      end
      if (got.updated !== e.updated) begin
        $error("updated: expected %0d, actual %0d", e.updated, got.updated);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    function void check_drained();
      if (expected_rsp.size() != 0) begin
        $error("%0d expected results never arrived", expected_rsp.size());
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  req_t       req;
  logic       cfg_we;
  logic [2:0] cfg_data;
  logic       done;
  rsp_t       rsp;

  route_table_model model = new();
  int quiet_cycles = 0;
  int items_sent = 0;
  bit gaps_on = 1'b1;

  distance_vector_route_update DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .rsp      (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) model.check_result(rsp);
      if (start && !busy) model.note_request(req);
      if (cfg_we) model.set_own(cfg_data);
    end
    if (done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_fields(logic [1:0] op, logic [2:0] nb, logic [3:0] lk,
                             logic [13:0] lcost, logic [2:0] dst, logic [13:0] adv,
                             logic first, logic last);
    req_t r;
    r.operation = op;
    r.neighbor = nb;
    r.link = lk;
    r.link_cost = lcost;
    r.dest_index = dst;
    r.advertised_cost = adv;
    r.first_element = first;
    r.last_element = last;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    if (op != OP_UNUSED) items_sent++;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // hold requests until every result is back, then let the pipeline empty
  task automatic settle_block();
    start <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_own(logic [2:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [13:0] pick_cost();
    case ($urandom_range(0, 9))
      0: return 14'd0;
      1: return INF_COST;
      2: return 14'($urandom_range(0, 10000));
      default: return 14'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic send_noise(logic [1:0] op);
    send_fields(op, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 14)),
                14'($urandom_range(0, 10000)), 3'($urandom_range(0, 7)),
                14'($urandom_range(0, 10000)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
  endtask

  task automatic send_vector(bit broken);
    logic [2:0]  nb;
    logic [3:0]  lk;
    logic [13:0] lcost;
    int          len;
    bit          keep_first;
    bit          keep_last;
    nb = 3'($urandom_range(0, 7));
    lk = 4'($urandom_range(0, 14));
    lcost = pick_cost();
    len = $urandom_range(1, 8);
    keep_first = !broken || $urandom_range(0, 1);
    keep_last = !broken || !keep_first;
    for (int i = 0; i < len; i++) begin
      send_fields(OP_VECTOR, nb, lk, lcost, 3'($urandom_range(0, 7)), pick_cost(),
                  keep_first && i == 0, keep_last && i == len - 1);
    end
  endtask

  task automatic run_random(int count);
    int  base;
    bit  paused;
    base = items_sent;
    paused = 1'b0;
    while (items_sent - base < count) begin
      case ($urandom_range(0, 19))
        0: send_noise(OP_CLEAR);
        1: send_noise(OP_UNUSED);
        2, 3: send_vector(1'b1);
        4, 5, 6, 7, 8: send_noise(OP_LOOKUP);
        default: send_vector(1'b0);
      endcase
      if (!paused && items_sent - base >= count / 2) begin
        settle_block();
        paused = 1'b1;
      end
    end
  endtask

  task automatic run_directed();
    send_fields(OP_LOOKUP, 3'd0, 4'd0, 14'd0, 3'd0, 14'd0, 1'b0, 1'b0);
    send_fields(OP_LOOKUP, 3'd7, 4'd14, INF_COST, 3'd7, INF_COST, 1'b1, 1'b1);
    send_fields(OP_UNUSED, 3'd5, 4'd3, 14'd12, 3'd5, 14'd7, 1'b1, 1'b1);
    send_fields(OP_VECTOR, 3'd3, 4'd14, 14'd0, 3'd6, INF_COST, 1'b1, 1'b0);
    send_fields(OP_VECTOR, 3'd3, 4'd14, 14'd0, 3'd5, 14'd0, 1'b0, 1'b1);
    send_fields(OP_VECTOR, 3'd3, 4'd14, 14'd0, 3'd6, INF_COST, 1'b1, 1'b1);
    send_fields(OP_VECTOR, 3'd7, 4'd0, INF_COST, 3'd7, INF_COST, 1'b1, 1'b1);
    send_fields(OP_VECTOR, 3'd1, 4'd2, 14'd5, 3'd2, 14'd1, 1'b1, 1'b0);
    send_fields(OP_VECTOR, 3'd1, 4'd2, 14'd5, 3'd2, 14'd1, 1'b1, 1'b1);
    send_fields(OP_LOOKUP, 3'd0, 4'd0, 14'd0, 3'd2, 14'd0, 1'b0, 1'b0);
    send_fields(OP_LOOKUP, 3'd0, 4'd0, 14'd0, 3'd1, 14'd0, 1'b0, 1'b0);
    send_fields(OP_LOOKUP, 3'd0, 4'd0, 14'd0, 3'd6, 14'd0, 1'b0, 1'b0);
    send_fields(OP_LOOKUP, 3'd0, 4'd0, 14'd0, 3'd5, 14'd0, 1'b0, 1'b0);
    send_fields(OP_VECTOR, 3'd0, 4'd14, INF_COST, 3'd3, 14'd0, 1'b1, 1'b1);
    send_fields(OP_LOOKUP, 3'd0, 4'd0, 14'd0, 3'd0, 14'd0, 1'b0, 1'b0);
    send_fields(OP_VECTOR, 3'd6, 4'd9, 14'd9999, 3'd4, 14'd9999, 1'b1, 1'b1);
    send_fields(OP_LOOKUP, 3'd0, 4'd0, 14'd0, 3'd6, 14'd0, 1'b0, 1'b0);
    send_fields(OP_CLEAR, 3'd7, 4'd14, INF_COST, 3'd7, INF_COST, 1'b1, 1'b1);
    send_fields(OP_LOOKUP, 3'd0, 4'd0, 14'd0, 3'd3, 14'd0, 1'b0, 1'b0);
    send_fields(OP_LOOKUP, 3'd0, 4'd0, 14'd0, 3'd0, 14'd0, 1'b0, 1'b0);
    send_fields(OP_VECTOR, 3'd4, 4'd1, 14'd3, 3'd4, 14'd0, 1'b0, 1'b1);
    send_fields(OP_LOOKUP, 3'd0, 4'd0, 14'd0, 3'd4, 14'd0, 1'b0, 1'b0);
  endtask

  initial begin
    logic [2:0] own_seq [5];
    own_seq = '{3'd7, 3'd0, 3'd4, 3'd1, 3'd7};
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < 5; p++) begin
      settle_block();
      write_own(p == 2 ? 3'($urandom_range(0, 7)) : own_seq[p]);
      // keep the old table once so the own entry is left stale
      if (p != 1) send_fields(OP_CLEAR, 3'd0, 4'd0, 14'd0, 3'd0, 14'd0, 1'b0, 1'b0);
      gaps_on = (p < 4);
      run_random(276);
    end
    start <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    model.check_drained();
    if (model.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dvru_pkg.sv
hw/rtl/dvru_table.sv
hw/rtl/distance_vector_route_update.sv
tb/sv/tb_distance_vector_route_update.sv
